### hw/rtl/assert_macros.svh
// Assertion macros shared by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/spd_pkg.sv
// Types and constants of the silence and pause detector.
package spd_pkg;

    // Channels at or above this number never count towards the level
    localparam int MAX_CHANNELS = 16;

    // Event queue depth (power of two, at least two)
    localparam int FIFO_DEPTH = 4;

    localparam logic [31:0] SUM_MAX   = 32'hFFFF_FFFF;
    localparam logic [20:0] COUNT_MAX = 21'h1F_FFFF;
    localparam logic [23:0] MS_MAX    = 24'hFF_FFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CHANNEL_MASK    = 2'd0,
        CFG_SILENCE_LEVEL   = 2'd1,
        CFG_SILENCE_HOLD_MS = 2'd2,
        CFG_PAUSE_HOLD_MS   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        EV_SILENCE_ON  = 2'd0,
        EV_SILENCE_OFF = 2'd1,
        EV_PAUSE_ON    = 2'd2,
        EV_PAUSE_OFF   = 2'd3
    } evt_kind_t;

    // One result item
    typedef struct packed {
        evt_kind_t   kind;
        logic [23:0] duration;
        logic        last;
    } evt_t;

    // Up to two events pushed per processed item; push1 implies push0
    typedef struct packed {
        logic push0;
        logic push1;
        evt_t evt0;
        evt_t evt1;
    } evt_push_t;

endpackage

### hw/rtl/spd_evt_fifo.sv
// Event queue: takes up to two events per cycle, hands out one per cycle unless out_stall holds it.
module spd_evt_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  spd_pkg::evt_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output spd_pkg::evt_t      out_evt
);
    import spd_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    evt_t             entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign out_valid    = (count_reg != '0);
    assign out_evt      = entries_reg[rd_ptr_reg];
    assign pop          = out_valid && !out_stall;
    assign room         = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.push0) + PTR_W'(push.push1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.push0)
            entries_reg[wr_ptr_reg] <= push.evt0;
        if (push.push1)
            entries_reg[wr_ptr_plus1] <= push.evt1;
    end

    `ASSERT_IMPLIES(a_push_has_room, clk, rst_n, push.push0, count_reg <= CNT_W'(FIFO_DEPTH - 2))
    `ASSERT_IMPLIES(a_push_packed, clk, rst_n, push.push1, push.push0)

endmodule

### hw/rtl/silence_pause_detector_core.sv
// Top level of the silence and pause detector.
// An accepted item waits in the input register until the queue has room, then pushes its events there.
// Throughput: one item per cycle unless in_stall; events leave a four-entry queue one per cycle unless out_stall.
// Reset clears accumulators, silence state and queue; registers return to their defaults.
module silence_pause_detector_core (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [15:0] sample,
    input  logic [3:0]         channel,
    input  logic               buffer_end,
    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_kind,
    output logic [23:0]        duration_ms,
    output logic               last
);
    import spd_pkg::*;
    `include "assert_macros.svh"

    // Configuration registers
    logic [15:0] channel_mask_reg;
    logic [14:0] silence_level_reg;
    logic [15:0] silence_hold_ms_reg;
    logic [15:0] pause_hold_ms_reg;

    // Input register
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_action_reg;
    logic signed [15:0] s1_sample_reg;
    logic [3:0]         s1_channel_reg;
    logic               s1_buffer_end_reg;

    // Detector state
    logic [31:0] level_sum_reg, level_sum_next;
    logic [20:0] level_count_reg, level_count_next;
    logic        was_silent_reg, was_silent_next;
    logic        in_silence_reg, in_silence_next;
    logic        in_pause_reg, in_pause_next;
    logic [23:0] silence_ms_reg, silence_ms_next;

    // Datapath
    logic        in_accept;
    logic        s1_go;
    logic        room;
    logic        is_sample;
    logic        chan_on;
    logic [15:0] mag;
    logic [32:0] sum_wide;
    logic [31:0] sum_eff;
    logic [20:0] count_eff;
    logic [35:0] threshold;
    logic        silent;
    logic        eval;
    logic        enter_sil;
    logic        leave_sil;
    logic        stay_sil;
    logic [23:0] ms_eff;
    logic        e0_v, e1_v;
    evt_t        e0, e1;
    evt_push_t   push;
    evt_t        out_evt;

    // Handshake
    assign s1_go     = s1_valid_reg && room;
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mask_reg    <= 16'd1;
            silence_level_reg   <= 15'd328;
            silence_hold_ms_reg <= 16'd500;
            pause_hold_ms_reg   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CHANNEL_MASK:    channel_mask_reg    <= cfg_data;
                CFG_SILENCE_LEVEL:   silence_level_reg   <= cfg_data[14:0];
                CFG_SILENCE_HOLD_MS: silence_hold_ms_reg <= cfg_data;
                CFG_PAUSE_HOLD_MS:   pause_hold_ms_reg   <= cfg_data;
            endcase
        end
    end

    // Input register
    assign s1_valid_next = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg     <= action;
            s1_sample_reg     <= sample;
            s1_channel_reg    <= channel;
            s1_buffer_end_reg <= buffer_end;
        end
    end

    // Level accumulation and silence decision
    always_comb
    begin
        is_sample = !s1_action_reg;
        chan_on   = (32'(s1_channel_reg) < 32'(MAX_CHANNELS))
                    && channel_mask_reg[s1_channel_reg];
        mag       = s1_sample_reg[15] ? (~$unsigned(s1_sample_reg) + 16'd1)
                                      : $unsigned(s1_sample_reg);
        sum_wide  = {1'b0, level_sum_reg} + {17'b0, mag};
        if (is_sample && chan_on)
        begin
            sum_eff   = sum_wide[32] ? SUM_MAX : sum_wide[31:0];
            count_eff = (level_count_reg != COUNT_MAX) ? level_count_reg + 21'd1
                                                       : level_count_reg;
        end
        else
        begin
            sum_eff   = level_sum_reg;
            count_eff = level_count_reg;
        end
        // mean < level, as sum < level * count
        threshold = {21'b0, silence_level_reg} * {15'b0, count_eff};
        silent    = {4'b0, sum_eff} < threshold;
    end

    // Transitions and events
    always_comb
    begin
        eval      = s1_go && is_sample && s1_buffer_end_reg;
        enter_sil = eval && silent && !was_silent_reg;
        leave_sil = eval && !silent && was_silent_reg;
        stay_sil  = eval && !leave_sil && (enter_sil || in_silence_reg);
        ms_eff    = enter_sil ? '0 : silence_ms_reg;

        e0_v = 1'b0;
        e1_v = 1'b0;
        e0   = '{kind: EV_SILENCE_OFF, duration: silence_ms_reg, last: 1'b0};
        e1   = '{kind: EV_PAUSE_OFF, duration: silence_ms_reg, last: 1'b0};

        if (leave_sil)
        begin
            e0_v = silence_ms_reg > {8'b0, silence_hold_ms_reg};
            e1_v = in_pause_reg;
        end
        else if (stay_sil)
        begin
            e0_v = ms_eff > {8'b0, silence_hold_ms_reg};
            e0   = '{kind: EV_SILENCE_ON, duration: '0, last: 1'b0};
            if (ms_eff > {8'b0, pause_hold_ms_reg})
            begin
                e1_v = !in_pause_reg;
                e1   = '{kind: EV_PAUSE_ON, duration: '0, last: 1'b0};
            end
            else
            begin
                e1_v = in_pause_reg;
                e1   = '{kind: EV_PAUSE_OFF, duration: '0, last: 1'b0};
            end
        end

        // pack events into the queue slots, mark the final one
        push.push0 = e0_v || e1_v;
        push.push1 = e0_v && e1_v;
        push.evt0  = e0_v ? e0 : e1;
        push.evt0.last = !(e0_v && e1_v);
        push.evt1  = e1;
        push.evt1.last = 1'b1;
    end

    // State update
    always_comb
    begin
        level_sum_next   = level_sum_reg;
        level_count_next = level_count_reg;
        was_silent_next  = was_silent_reg;
        in_silence_next  = in_silence_reg;
        in_pause_next    = in_pause_reg;
        silence_ms_next  = silence_ms_reg;

        if (s1_go && !is_sample)
        begin
            // millisecond tick
            if (in_silence_reg && silence_ms_reg != MS_MAX)
                silence_ms_next = silence_ms_reg + 24'd1;
        end
        else if (s1_go)
        begin
            level_sum_next   = sum_eff;
            level_count_next = count_eff;
            if (eval)
            begin
                level_sum_next   = '0;
                level_count_next = '0;
                was_silent_next  = silent;
                if (enter_sil)
                begin
                    silence_ms_next = '0;
                    in_silence_next = 1'b1;
                end
                if (leave_sil)
                begin
                    in_silence_next = 1'b0;
                    in_pause_next   = 1'b0;
                end
                else if (stay_sil)
                    in_pause_next = ms_eff > {8'b0, pause_hold_ms_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_sum_reg   <= '0;
            level_count_reg <= '0;
            was_silent_reg  <= 1'b0;
            in_silence_reg  <= 1'b0;
            in_pause_reg    <= 1'b0;
            silence_ms_reg  <= '0;
        end
        else
        begin
            level_sum_reg   <= level_sum_next;
            level_count_reg <= level_count_next;
            was_silent_reg  <= was_silent_next;
            in_silence_reg  <= in_silence_next;
            in_pause_reg    <= in_pause_next;
            silence_ms_reg  <= silence_ms_next;
        end
    end

    // Result queue
    spd_evt_fifo u_evt_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_evt   (out_evt)
    );

    assign event_kind  = out_evt.kind;
    assign duration_ms = out_evt.duration;
    assign last        = out_evt.last;

    `ASSERT_IMPLIES(a_silence_flags_agree, clk, rst_n, 1'b1, was_silent_reg == in_silence_reg)
    `ASSERT_IMPLIES(a_pause_needs_silence, clk, rst_n, in_pause_reg, in_silence_reg)
    `ASSERT_NEXT(a_acc_cleared, clk, rst_n, eval, level_sum_reg == '0 && level_count_reg == '0)

endmodule
